// File: rtl/core/brcwd_pkg.sv
// Shared types, constants and helpers for the bit-reversed colour-wheel dither.
// Used by every module under rtl/core; depends on nothing else.
package brcwd_pkg;

    localparam int LC_W       = 11;  // light count register width
    localparam int PAT_W      = 3;   // pattern register width
    localparam int DITHER_W   = 15;  // dither counter width
    localparam int STEP_W     = 16;  // colour step width
    localparam int PIX_W      = 10;  // pixel index width
    localparam int CH_W       = 7;   // colour channel width
    localparam int JUMP_W     = 9;   // random jump field width
    localparam int JUMP_USE_W = 8;   // bits of the random jump that are used
    localparam int SCALE_W    = 3;   // random scale field width
    localparam int HPOS_W     = 4;   // holds a bit position of the light count
    localparam int WHEEL_W    = STEP_W + SCALE_W; // widest wheel source
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LC_W;

    localparam int INDEX_BITS_DEF = 10;

    localparam logic [LC_W-1:0] LC_RESET = LC_W'(50);

    // Steps added to the colour step at the end of a dither pass.
    localparam logic [STEP_W-1:0] LINE_PASS_STEP  = STEP_W'(24);
    localparam logic [STEP_W-1:0] WHEEL_PASS_STEP = STEP_W'(32);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN     = 1'b1;

    // Pattern codes.
    localparam logic [PAT_W-1:0] PAT_LINE_RG    = 3'd0;
    localparam logic [PAT_W-1:0] PAT_LINE_GB    = 3'd1;
    localparam logic [PAT_W-1:0] PAT_LINE_BR    = 3'd2;
    localparam logic [PAT_W-1:0] PAT_WHEEL_PASS = 3'd3;
    localparam logic [PAT_W-1:0] PAT_WHEEL_RAND = 3'd4;
    localparam logic [PAT_W-1:0] PAT_WHEEL_QTR  = 3'd5;
    localparam logic [PAT_W-1:0] PAT_WHEEL_TICK = 3'd6;
    localparam logic [PAT_W-1:0] PAT_WHEEL_MUL  = 3'd7;

    // Wheel segment codes.
    localparam logic [1:0] SEG_RG = 2'd0;
    localparam logic [1:0] SEG_GB = 2'd1;
    localparam logic [1:0] SEG_BR = 2'd2;

    typedef struct packed {
        logic [JUMP_W-1:0]  rand_jump;
        logic [SCALE_W-1:0] rand_scale;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_out_item;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_index;
        logic                pass_end;
        logic [DITHER_W-1:0] dither_next;
    } t_dither_info;

    // Residue modulo 3 of a 12-bit value: powers of four are 1 modulo 3, so
    // the base-4 digits are summed and the sum folded down again.
    function automatic logic [1:0] mod3_12(input logic [11:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int k = 0; k < 6; k++) begin
            s1 = s1 + 5'(v[2*k +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

endpackage

// File: rtl/core/bit_reversed_color_wheel_dither.sv
// An input transfer loads the input register; the result register is loaded from
// it when the result register is empty or its transfer completes (input register,
// then result register). Throughput: one item per cycle while the output is not
// stalled; the counter update for a tick completes in the single compute stage.
// Synchronous active-low reset clears the pipeline valids, the dither counter
// and colour step, and sets light_count to 50 and pattern to 0.
// Depends on brcwd_pkg, brcwd_index and brcwd_colour.
module bit_reversed_color_wheel_dither
    import brcwd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic [LC_W-1:0]     r_light_count;
    logic [PAT_W-1:0]    r_pattern;
    logic [DITHER_W-1:0] r_dither_count;
    logic [STEP_W-1:0]   r_colour_step;
    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                w_advance;
    logic                w_fire;
    t_dither_info        w_info;
    t_rgb                w_rgb;
    logic [STEP_W-1:0]   w_colour_step_next;

    // The compute stage moves on when the result register is empty or its
    // current transfer completes.
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_fire      = r_s1_valid && w_advance;
    assign o_in_ready  = !r_s1_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    brcwd_index #(
        .INDEX_BITS(INDEX_BITS)
    ) u_index (
        .i_light_count (r_light_count),
        .i_dither_count(r_dither_count),
        .o_info        (w_info)
    );

    brcwd_colour u_colour (
        .i_colour_step     (r_colour_step),
        .i_pattern         (r_pattern),
        .i_item            (r_s1_item),
        .i_pass_end        (w_info.pass_end),
        .o_rgb             (w_rgb),
        .o_colour_step_next(w_colour_step_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_count <= LC_RESET;
            r_pattern     <= PAT_LINE_RG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LIGHT_COUNT: r_light_count <= i_cfg_data[LC_W-1:0];
                REG_PATTERN:     r_pattern     <= i_cfg_data[PAT_W-1:0];
                default:         r_pattern     <= r_pattern;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_dither_count <= '0;
            r_colour_step  <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_fire) begin
                r_dither_count <= w_info.dither_next;
                r_colour_step  <= w_colour_step_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
        if (w_fire) begin
            r_out_item.pixel_index <= w_info.pixel_index;
            r_out_item.red         <= w_rgb.red;
            r_out_item.green       <= w_rgb.green;
            r_out_item.blue        <= w_rgb.blue;
        end
    end

    // The tick state only moves when an item passes through the compute stage.
    a_state_moves_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_dither_count) && $stable(r_colour_step))
        else $error("dither state changed without an item in the compute stage");

    // A stalled item waits in the input register unchanged.
    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_advance |=> r_s1_valid && $stable(r_s1_item))
        else $error("input register lost or changed a stalled item");

    // Back-pressure reaches the input only when both registers are full.
    a_ready_low_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input refused while the pipeline had room");

endmodule

// File: rtl/core/brcwd_index.sv
// Dither position unit: highest set bit of light_count-1, bit reversal of the
// dither counter over that width, and the end-of-pass test. Uses brcwd_pkg.
module brcwd_index
    import brcwd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic [LC_W-1:0]     i_light_count,
    input  logic [DITHER_W-1:0] i_dither_count,
    output t_dither_info        o_info
);

    // Only bits that exist in light_count-1 can be searched.
    localparam int SEARCH_BITS = (INDEX_BITS < LC_W) ? INDEX_BITS : LC_W;

    logic [LC_W-1:0]     w_n;
    logic                w_has_bit;
    logic [HPOS_W-1:0]   w_hpos;
    logic [LC_W-1:0]     w_rev_full;
    logic [LC_W-1:0]     w_rev;
    logic [HPOS_W-1:0]   w_shift;
    logic [DITHER_W-1:0] w_inc;
    logic [DITHER_W-1:0] w_target;

    assign w_n = i_light_count - LC_W'(1);

    always_comb begin
        w_has_bit = 1'b0;
        w_hpos    = '0;
        for (int i = 0; i < SEARCH_BITS; i++) begin
            if (w_n[i]) begin
                w_has_bit = 1'b1;
                w_hpos    = HPOS_W'(i);
            end
        end
    end

    // Reverse the low bits in full, then shift the unused positions away.
    always_comb begin
        for (int j = 0; j < LC_W; j++) begin
            w_rev_full[j] = i_dither_count[LC_W-1-j];
        end
    end

    assign w_shift  = HPOS_W'(LC_W - 1) - w_hpos;
    assign w_rev    = w_rev_full >> w_shift;
    assign w_inc    = i_dither_count + DITHER_W'(1);
    assign w_target = w_has_bit ? (DITHER_W'(1) << (w_hpos + HPOS_W'(1))) : '0;

    always_comb begin
        o_info.pixel_index = w_has_bit ? w_rev[PIX_W-1:0] : '0;
        o_info.pass_end    = (w_inc == w_target);
        o_info.dither_next = o_info.pass_end ? '0 : w_inc;
    end

endmodule

// File: rtl/core/brcwd_colour.sv
// Colour unit: maps the colour step to a two-colour line or three-colour
// wheel by pattern and works out the next colour step. Uses brcwd_pkg.
module brcwd_colour
    import brcwd_pkg::*;
(
    input  logic [STEP_W-1:0] i_colour_step,
    input  logic [PAT_W-1:0]  i_pattern,
    input  t_in_item          i_item,
    input  logic              i_pass_end,
    output t_rgb              o_rgb,
    output logic [STEP_W-1:0] o_colour_step_next
);

    logic [WHEEL_W-1:0] w_product;
    logic [WHEEL_W-1:0] w_wheel_src;
    logic [1:0]         w_seg;
    logic [CH_W-1:0]    w_wq;
    logic [CH_W-1:0]    w_lq;
    logic [CH_W-1:0]    w_fade_a;
    logic [CH_W-1:0]    w_fade_b;
    t_rgb               w_wheel;
    t_rgb               w_line;
    logic [STEP_W-1:0]  w_pass_step;
    logic [STEP_W-1:0]  w_add;

    assign w_product = WHEEL_W'(i_colour_step) * WHEEL_W'(i_item.rand_scale);

    always_comb begin
        case (i_pattern) inside
            PAT_WHEEL_QTR: w_wheel_src = WHEEL_W'(i_colour_step[STEP_W-1:2]);
            PAT_WHEEL_MUL: w_wheel_src = w_product;
            default:       w_wheel_src = WHEEL_W'(i_colour_step);
        endcase
    end

    // Position modulo 384: the low seven bits give the place in a segment and
    // the remaining bits modulo 3 give the segment.
    assign w_wq  = w_wheel_src[CH_W-1:0];
    assign w_seg = mod3_12(w_wheel_src[WHEEL_W-1:CH_W]);

    always_comb begin
        unique case (w_seg)
            SEG_RG: begin
                w_wheel.red = ~w_wq; w_wheel.green = w_wq; w_wheel.blue = '0;
            end
            SEG_GB: begin
                w_wheel.red = '0; w_wheel.green = ~w_wq; w_wheel.blue = w_wq;
            end
            SEG_BR: begin
                w_wheel.red = w_wq; w_wheel.green = '0; w_wheel.blue = ~w_wq;
            end
            default: begin
                w_wheel = '0;
            end
        endcase
    end

    // Line: the first channel fades down then up, the second the other way.
    assign w_lq     = i_colour_step[CH_W-1:0];
    assign w_fade_a = i_colour_step[CH_W] ? w_lq : ~w_lq;
    assign w_fade_b = i_colour_step[CH_W] ? ~w_lq : w_lq;

    always_comb begin
        w_line = '0;
        case (i_pattern)
            PAT_LINE_RG: begin
                w_line.red = w_fade_a; w_line.green = w_fade_b;
            end
            PAT_LINE_GB: begin
                w_line.green = w_fade_a; w_line.blue = w_fade_b;
            end
            default: begin
                w_line.blue = w_fade_a; w_line.red = w_fade_b;
            end
        endcase
    end

    always_comb begin
        case (i_pattern) inside
            PAT_LINE_RG, PAT_LINE_GB, PAT_LINE_BR: begin
                o_rgb       = w_line;
                w_pass_step = LINE_PASS_STEP;
            end
            PAT_WHEEL_PASS: begin
                o_rgb       = w_wheel;
                w_pass_step = WHEEL_PASS_STEP;
            end
            PAT_WHEEL_RAND: begin
                o_rgb       = w_wheel;
                w_pass_step = STEP_W'(i_item.rand_jump[JUMP_USE_W-1:0]);
            end
            default: begin
                o_rgb       = w_wheel;
                w_pass_step = '0;
            end
        endcase
    end

    // Per-frame patterns step by one on every tick and add nothing at pass end.
    always_comb begin
        if (i_pattern >= PAT_WHEEL_QTR) begin
            w_add = STEP_W'(1);
        end else if (i_pass_end) begin
            w_add = w_pass_step;
        end else begin
            w_add = '0;
        end
    end

    assign o_colour_step_next = i_colour_step + w_add;

endmodule

// File: dv/bit_reversed_color_wheel_dither_tb.sv
// Self-checking testbench for the bit-reversed colour-wheel dither: a queue-fed driver,
// an in-bench model of the pixel and colour for each frame tick, and a result checker.
// Depends on brcwd_pkg and the bit_reversed_color_wheel_dither top level.
module bit_reversed_color_wheel_dither_tb;
    import brcwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int IDLE_PCT = 34;
    localparam int SHOWN_FAULTS = 30;
    localparam int PHASES = 19;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_LIGHT_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    bit_reversed_color_wheel_dither uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state, kept in step with the block's registers and counters.
    logic [LC_W-1:0]     strip_len = LC_RESET;
    logic [PAT_W-1:0]    effect = PAT_LINE_RG;
    logic [DITHER_W-1:0] dither_pos = '0;
    logic [STEP_W-1:0]   hue_step = '0;

    t_in_item  frame_ticks [$];
    t_out_item colour_due [$];
    int        fault_count = 0;
    int        results_seen = 0;
    logic      in_fire = 1'b0;
    logic      calm = 1'b0;

    // Light count, pattern, length and quiet flag of each phase.
    int ph_lc [PHASES] = '{2, 3, 4, 5, 8, 9, 16, 17, 33, 50, 65, 128, 129, 513,
                           1024, 2047, 0, 1025, 1};
    logic [PAT_W-1:0] ph_pat [PHASES] = '{
        PAT_WHEEL_RAND, PAT_LINE_RG, PAT_LINE_GB, PAT_LINE_BR, PAT_WHEEL_PASS,
        PAT_WHEEL_QTR, PAT_WHEEL_TICK, PAT_WHEEL_MUL, PAT_WHEEL_RAND, PAT_LINE_RG,
        PAT_LINE_GB, PAT_WHEEL_PASS, PAT_WHEEL_MUL, PAT_WHEEL_RAND, PAT_LINE_BR,
        PAT_WHEEL_QTR, PAT_WHEEL_TICK, PAT_WHEEL_PASS, PAT_LINE_RG};
    int ph_len [PHASES] = '{40, 30, 30, 30, 30, 30, 30, 40, 50, 60, 60, 60, 120,
                            40, 30, 30, 30, 30, 30};
    bit ph_calm [PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
                             0, 0, 0, 0, 0};
    logic [PAT_W-1:0] every_pat [8] = '{
        PAT_LINE_RG, PAT_LINE_GB, PAT_LINE_BR, PAT_WHEEL_PASS,
        PAT_WHEEL_RAND, PAT_WHEEL_QTR, PAT_WHEEL_TICK, PAT_WHEEL_MUL};

    function automatic t_rgb wheel_rgb(input logic [8:0] pos);
        t_rgb            c;
        logic [CH_W-1:0] q;
        q = pos[6:0];
        c = '0;
        case (pos[8:7])
            SEG_RG: begin
                c.red   = ~q;
                c.green = q;
            end
            SEG_GB: begin
                c.green = ~q;
                c.blue  = q;
            end
            default: begin
                c.red  = q;
                c.blue = ~q;
            end
        endcase
        return c;
    endfunction

    // The first channel fades down over the first half and back up over the second.
    function automatic t_rgb line_rgb(input logic [7:0] pos, input int ch_a, input int ch_b);
        logic [CH_W-1:0] lvl [3];
        logic [CH_W-1:0] q;
        t_rgb            c;
        q = pos[6:0];
        lvl = '{default: '0};
        lvl[ch_a] = pos[7] ? q : ~q;
        lvl[ch_b] = pos[7] ? ~q : q;
        c.red   = lvl[CH_R];
        c.green = lvl[CH_G];
        c.blue  = lvl[CH_B];
        return c;
    endfunction

    // Works out the pixel and colour for one frame tick and advances the counters.
    function automatic t_out_item paint_tick(input t_in_item it);
        logic [LC_W-1:0]     n;
        logic [DITHER_W-1:0] top;
        logic [DITHER_W-1:0] rev;
        logic [DITHER_W-1:0] nxt;
        logic [STEP_W-1:0]   adv;
        logic [WHEEL_W-1:0]  prod;
        t_rgb                c;
        t_out_item           r;
        n = strip_len - 1'b1;
        top = '0;
        for (int i = 0; i < INDEX_BITS_DEF && i < DITHER_W; i++) begin
            if (n[i]) begin
                top = DITHER_W'(1 << i);
            end
        end
        rev = '0;
        for (int b = 0; b < DITHER_W; b++) begin
            if ((1 << b) <= int'(top)) begin
                rev = {rev[DITHER_W-2:0], dither_pos[b]};
            end
        end
        adv = '0;
        case (effect)
            PAT_LINE_RG: begin
                c = line_rgb(hue_step[7:0], CH_R, CH_G);
                adv = LINE_PASS_STEP;
            end
            PAT_LINE_GB: begin
                c = line_rgb(hue_step[7:0], CH_G, CH_B);
                adv = LINE_PASS_STEP;
            end
            PAT_LINE_BR: begin
                c = line_rgb(hue_step[7:0], CH_B, CH_R);
                adv = LINE_PASS_STEP;
            end
            PAT_WHEEL_PASS: begin
                c = wheel_rgb(9'(hue_step % 384));
                adv = WHEEL_PASS_STEP;
            end
            PAT_WHEEL_RAND: begin
                c = wheel_rgb(9'(hue_step % 384));
                adv = STEP_W'(it.rand_jump[JUMP_USE_W-1:0]);
            end
            PAT_WHEEL_QTR: begin
                c = wheel_rgb(9'((hue_step >> 2) % 384));
                hue_step = hue_step + 1'b1;
            end
            PAT_WHEEL_TICK: begin
                c = wheel_rgb(9'(hue_step % 384));
                hue_step = hue_step + 1'b1;
            end
            default: begin
                // The product is kept at full width before the wheel reduction.
                prod = WHEEL_W'(hue_step) * WHEEL_W'(it.rand_scale);
                c = wheel_rgb(9'(prod % 384));
                hue_step = hue_step + 1'b1;
            end
        endcase
        r.pixel_index = rev[PIX_W-1:0];
        r.red   = c.red;
        r.green = c.green;
        r.blue  = c.blue;
        nxt = dither_pos + 1'b1;
        if (nxt == DITHER_W'(top << 1)) begin
            dither_pos = '0;
            hue_step = hue_step + adv;
        end else begin
            dither_pos = nxt;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
            $display("%0t: result %0d: %s", $realtime, results_seen, msg);
        end
    endtask

    // Input transfers feed the model; output transfers are checked against it.
    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            colour_due.push_back(paint_tick(i_in_data));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            results_seen++;
            if (colour_due.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = colour_due.pop_front();
                if (got.pixel_index !== want.pixel_index)
                    report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                              got.pixel_index, want.pixel_index));
                if (got.red !== want.red)
                    report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green %0d, expected %0d",
                                              got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (frame_ticks.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_data  <= frame_ticks.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic push_tick(input logic [JUMP_W-1:0] jump, input logic [SCALE_W-1:0] scale);
        t_in_item it;
        it.rand_jump  = jump;
        it.rand_scale = scale;
        frame_ticks.push_back(it);
    endtask

    // Returns once every queued tick has been transferred and every result checked.
    task automatic wait_drained();
        while (frame_ticks.size() != 0 || i_in_valid || colour_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_LIGHT_COUNT) begin
            strip_len = val;
        end else begin
            effect = val[PAT_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int count;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One tick under the reset configuration, then every pattern on a two-pixel strip
        // with the extremes of both random fields.
        push_tick('0, '0);
        wait_drained();
        cfg_write(REG_LIGHT_COUNT, CFG_DATA_W'(2));
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            cfg_write(REG_PATTERN, CFG_DATA_W'(every_pat[p]));
            push_tick('0, '0);
            push_tick('1, '1);
            push_tick(JUMP_W'(1 << JUMP_USE_W), SCALE_W'($urandom_range(7)));
        end

        // Pass lengths never fall so that the dither counter stays below each new pass
        // length; the strips without a usable top bit come last, as their passes end
        // only when the dither counter wraps.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            cfg_write(REG_LIGHT_COUNT, CFG_DATA_W'(ph_lc[ph]));
            cfg_write(REG_PATTERN, CFG_DATA_W'(ph_pat[ph]));
            count = ph_len[ph];
            calm = ph_calm[ph];
            for (int k = 0; k < count; k++) begin
                push_tick(JUMP_W'($urandom_range((1 << JUMP_W) - 1)),
                          SCALE_W'($urandom_range((1 << SCALE_W) - 1)));
            end
        end

        wait_drained();
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("bit_reversed_color_wheel_dither_tb: done, clean");
        end else begin
            $display("bit_reversed_color_wheel_dither_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("bit_reversed_color_wheel_dither_tb: done, errors");
        $finish;
    end

endmodule
